>>> rtl/core/lpg_pkg.sv
// Shared types and constants of the line pixel generator.
package lpg_pkg;

  // Default screen geometry: columns, and pages of eight rows each.
  localparam int SCREEN_COLUMNS_DEF = 128;
  localparam int SCREEN_PAGES_DEF   = 8;

  // Number of rows in one frame-buffer page.
  localparam int PAGE_ROWS = 8;

  // Entries in the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Stream widths.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  // Item kinds carried on the input tuser bit.
  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_t;

  // A classified item as it waits in the queue.
  typedef struct packed {
    action_t    action;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [7:0] major_delta;
    logic [7:0] minor_delta;
    logic       x_negative;
    logic       y_negative;
    logic       x_is_major;
    logic       color;
  } cmd_t;

  // Status of the queue head as seen by the back.
  typedef struct packed {
    logic valid;
  } qhs_t;

endpackage

>>> rtl/core/line_pixel_generator.sv
// Top level of the line pixel generator: front, queue and Bresenham back.
//
//   channel  direction  tdata                                         tuser       tlast
//   in_      slave      start_x,start_y,end_x,end_y,draw_color (40b)  action      -
//   out_     master     pixel_x,pixel_y,byte_address,bit_index,       offscreen   last_pixel
//                       set_bit (32b)
//
// One item is accepted per clock while in_tready is high; a start item, or an advance
// item on an active line, gives its pixel through a two-entry queue and the output
// register. An advance item while no line is active is dropped without a pixel.
// Sustained rate, set by the walk update, is one pixel per clock with out_tready high.
// Reset (rst_n low, synchronous) empties the queue and leaves no line active.
// An output stall fills the queue, after which in_tready drops.
module line_pixel_generator #(
  parameter int SCREEN_COLUMNS = lpg_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_PAGES   = lpg_pkg::SCREEN_PAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // start_x[7:0], start_y[15:8], end_x[23:16], end_y[31:24], draw_color[32]
  input  logic [lpg_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action: 0 start, 1 advance
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // pixel_x[7:0], pixel_y[15:8], byte_address[25:16], bit_index[28:26], set_bit[29]
  output logic [lpg_pkg::OUT_TDATA_W-1:0] out_tdata,
  // offscreen
  output logic                            out_tuser,
  output logic                            out_tlast
);

  lpg_pkg::cmd_t front_cmd;
  lpg_pkg::cmd_t head_cmd;
  lpg_pkg::qhs_t head_hs;
  logic          q_full, pop;

  assign in_tready = !q_full;

  lpg_front u_front (
    .in_action (lpg_pkg::action_t'(in_tuser)),
    .in_data   (in_tdata),
    .cmd       (front_cmd)
  );

  lpg_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (in_tvalid),
    .push_cmd    (front_cmd),
    .full        (q_full),
    .head_hs_out (head_hs),
    .pop         (pop),
    .head_cmd    (head_cmd)
  );

  lpg_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_PAGES   (SCREEN_PAGES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_hs    (head_hs),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/core/lpg_front.sv
// Front of the line pixel generator: unpacks and classifies input items.
module lpg_front (
  input  lpg_pkg::action_t                 in_action,
  input  logic [lpg_pkg::IN_TDATA_W-1:0]   in_data,
  output lpg_pkg::cmd_t                    cmd
);

  logic [7:0] sx, sy, ex, ey;
  logic [7:0] dx, dy, ax, ay;
  logic       xneg, yneg, xmaj;

  // Field extraction, lowest field first.
  assign sx = in_data[7:0];
  assign sy = in_data[15:8];
  assign ex = in_data[23:16];
  assign ey = in_data[31:24];

  // Signed deltas, their magnitudes and the major axis.
  always_comb begin
    dx   = ex - sx;
    dy   = ey - sy;
    xneg = dx[7];
    yneg = dy[7];
    ax   = xneg ? (8'd0 - dx) : dx;
    ay   = yneg ? (8'd0 - dy) : dy;
    xmaj = (ax >= ay);
  end

  // Build the queue entry; geometry fields are ignored by the back on advance items.
  always_comb begin
    cmd.action      = in_action;
    cmd.start_x     = sx;
    cmd.start_y     = sy;
    cmd.major_delta = xmaj ? ax : ay;
    cmd.minor_delta = xmaj ? ay : ax;
    cmd.x_negative  = xneg;
    cmd.y_negative  = yneg;
    cmd.x_is_major  = xmaj;
    cmd.color       = in_data[32];
  end

endmodule

>>> rtl/core/lpg_queue.sv
// Short register queue between the front and the back.
module lpg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lpg_pkg::cmd_t  push_cmd,
  output logic           full,
  output lpg_pkg::qhs_t  head_hs_out,
  input  logic           pop,
  output lpg_pkg::cmd_t  head_cmd
);

  localparam int PtrW = $clog2(lpg_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(lpg_pkg::QUEUE_DEPTH + 1);

  lpg_pkg::cmd_t  entry_r [lpg_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  // Status towards both sides.
  assign full              = (count_r == CntW'(lpg_pkg::QUEUE_DEPTH));
  assign head_hs_out.valid = (count_r != '0);
  assign head_cmd          = entry_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && (count_r != '0);

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(lpg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(lpg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/core/lpg_back.sv
// Back of the line pixel generator: Bresenham walk and pixel output register.
module lpg_back #(
  parameter int SCREEN_COLUMNS = lpg_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_PAGES   = lpg_pkg::SCREEN_PAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lpg_pkg::qhs_t                   head_hs,
  input  lpg_pkg::cmd_t                   head_cmd,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lpg_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser,
  output logic                            out_tlast
);

  localparam int ColW  = $clog2(SCREEN_COLUMNS + 1);
  localparam int ProdW = 5 + ColW;
  localparam int SumW  = (ProdW + 1 > 10) ? ProdW + 1 : 10;

  // Walk state.
  logic [7:0] cur_x_r, cur_x_nxt;
  logic [7:0] cur_y_r, cur_y_nxt;
  logic [7:0] error_acc_r, error_acc_nxt;
  logic [7:0] major_delta_r, major_delta_nxt;
  logic [7:0] minor_delta_r, minor_delta_nxt;
  logic [7:0] steps_left_r, steps_left_nxt;
  logic       x_negative_r, x_negative_nxt;
  logic       y_negative_r, y_negative_nxt;
  logic       x_is_major_r, x_is_major_nxt;
  logic       line_color_r, line_color_nxt;
  logic       busy_r, busy_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] px_r, px_nxt;
  logic [7:0] py_r, py_nxt;
  logic [9:0] addr_r, addr_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic       set_r, set_nxt;
  logic       off_r, off_nxt;
  logic       last_r, last_nxt;

  logic       out_free, emit;
  logic [7:0] err_sum;
  logic [4:0] page;
  logic [SumW-1:0] addr_full;

  // The head is taken whenever the output register is free or being emptied.
  assign out_free = !out_valid_r || out_tready;
  assign pop      = head_hs.valid && out_free;

  // Walk update for a start or an advance item.
  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    error_acc_nxt   = error_acc_r;
    major_delta_nxt = major_delta_r;
    minor_delta_nxt = minor_delta_r;
    steps_left_nxt  = steps_left_r;
    x_negative_nxt  = x_negative_r;
    y_negative_nxt  = y_negative_r;
    x_is_major_nxt  = x_is_major_r;
    line_color_nxt  = line_color_r;
    busy_nxt        = busy_r;
    emit            = 1'b0;
    err_sum         = error_acc_r + minor_delta_r;
    if (pop) begin
      case (head_cmd.action)
        lpg_pkg::ACT_START: begin
          cur_x_nxt       = head_cmd.start_x;
          cur_y_nxt       = head_cmd.start_y;
          major_delta_nxt = head_cmd.major_delta;
          minor_delta_nxt = head_cmd.minor_delta;
          error_acc_nxt   = {1'b0, head_cmd.major_delta[7:1]};
          steps_left_nxt  = head_cmd.major_delta;
          x_negative_nxt  = head_cmd.x_negative;
          y_negative_nxt  = head_cmd.y_negative;
          x_is_major_nxt  = head_cmd.x_is_major;
          line_color_nxt  = head_cmd.color;
          busy_nxt        = (head_cmd.major_delta != 8'd0);
          emit            = 1'b1;
        end
        lpg_pkg::ACT_ADVANCE: begin
          if (busy_r) begin
            error_acc_nxt = err_sum;
            if (err_sum >= major_delta_r) begin
              error_acc_nxt = err_sum - major_delta_r;
              if (x_is_major_r) begin
                cur_y_nxt = y_negative_r ? cur_y_r - 8'd1 : cur_y_r + 8'd1;
              end else begin
                cur_x_nxt = x_negative_r ? cur_x_r - 8'd1 : cur_x_r + 8'd1;
              end
            end
            if (x_is_major_r) begin
              cur_x_nxt = x_negative_r ? cur_x_r - 8'd1 : cur_x_r + 8'd1;
            end else begin
              cur_y_nxt = y_negative_r ? cur_y_r - 8'd1 : cur_y_r + 8'd1;
            end
            steps_left_nxt = steps_left_r - 8'd1;
            busy_nxt       = (steps_left_r != 8'd1);
            emit           = 1'b1;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // Pixel fields from the new position.
  always_comb begin
    page      = cur_y_nxt[7:3];
    addr_full = SumW'(page * ColW'(SCREEN_COLUMNS)) + SumW'(cur_x_nxt);
    off_nxt   = ({1'b0, cur_x_nxt} >= 9'(SCREEN_COLUMNS)) ||
                ({1'b0, cur_y_nxt} >= 9'(SCREEN_PAGES * lpg_pkg::PAGE_ROWS));
    px_nxt    = cur_x_nxt;
    py_nxt    = cur_y_nxt;
    addr_nxt  = off_nxt ? 10'd0 : addr_full[9:0];
    bit_nxt   = cur_y_nxt[2:0];
    set_nxt   = line_color_nxt;
    last_nxt  = !busy_nxt;
  end

  // Output valid: set by a new pixel, cleared when taken.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      error_acc_r   <= '0;
      major_delta_r <= '0;
      minor_delta_r <= '0;
      steps_left_r  <= '0;
      x_negative_r  <= 1'b0;
      y_negative_r  <= 1'b0;
      x_is_major_r  <= 1'b0;
      line_color_r  <= 1'b0;
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      error_acc_r   <= error_acc_nxt;
      major_delta_r <= major_delta_nxt;
      minor_delta_r <= minor_delta_nxt;
      steps_left_r  <= steps_left_nxt;
      x_negative_r  <= x_negative_nxt;
      y_negative_r  <= y_negative_nxt;
      x_is_major_r  <= x_is_major_nxt;
      line_color_r  <= line_color_nxt;
      busy_r        <= busy_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Pixel payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      addr_r <= addr_nxt;
      bit_r  <= bit_nxt;
      set_r  <= set_nxt;
      off_r  <= off_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, set_r, bit_r, addr_r, py_r, px_r};
  assign out_tuser  = off_r;
  assign out_tlast  = last_r;

  // A live line always has steps to go and an error below the major delta.
  a_busy_steps: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> steps_left_r != 8'd0)
    else $error("line active with no steps left");

  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> error_acc_r < major_delta_r)
    else $error("error accumulator out of range");

  // The final pixel of a line leaves the walker idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last_nxt) |=> !busy_r)
    else $error("walker still active after last pixel");

  // An offscreen pixel never carries a frame-buffer address.
  a_off_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && off_r) |-> addr_r == 10'd0)
    else $error("offscreen pixel with non-zero address");

endmodule
